[rtl/rpn_pkg.sv]
// Package: shared types, codes and constants of the postfix evaluator.
package rpn_pkg;

    localparam int STACK_ENTRIES_DEF = 64;
    localparam int POS_BITS_DEF      = 16;
    localparam int LN_STEPS          = 43;

    // Token operation codes.
    localparam logic [3:0] OP_PUSH   = 4'd0;
    localparam logic [3:0] OP_ADD    = 4'd1;
    localparam logic [3:0] OP_SUB    = 4'd2;
    localparam logic [3:0] OP_MUL    = 4'd3;
    localparam logic [3:0] OP_DIV    = 4'd4;
    localparam logic [3:0] OP_MOD    = 4'd5;
    localparam logic [3:0] OP_CONCAT = 4'd6;
    localparam logic [3:0] OP_POW    = 4'd7;
    localparam logic [3:0] OP_NEG    = 4'd8;
    localparam logic [3:0] OP_LN     = 4'd9;

    // Status codes.
    localparam logic [3:0] ST_OK     = 4'd0;
    localparam logic [3:0] ST_UNARY  = 4'd1;
    localparam logic [3:0] ST_BINARY = 4'd2;
    localparam logic [3:0] ST_OVF    = 4'd3;
    localparam logic [3:0] ST_DIVZ   = 4'd4;
    localparam logic [3:0] ST_NEGEXP = 4'd5;
    localparam logic [3:0] ST_BADLOG = 4'd6;
    localparam logic [3:0] ST_STRUCT = 4'd7;
    localparam logic [3:0] ST_FULL   = 4'd8;

    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] SAT_CAP = 64'h8000_0000_0000_0001;

    typedef struct packed {
        logic [3:0]  mode;
        logic [62:0] literal;
        logic [15:0] token_pos;
        logic        last;
    } rpn_in_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic [3:0]         status;
        logic [15:0]        error_pos;
        logic               done_res;
    } rpn_out_t;

    // Command from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic        start;
        logic [3:0]  mode;
        logic [63:0] a;
        logic [63:0] b;
    } rpn_alu_cmd_t;

    // Reply from the arithmetic unit.
    typedef struct packed {
        logic        done;
        logic [3:0]  status;
        logic [63:0] result;
    } rpn_alu_rsp_t;

    // Thresholds ceil(e^k) for k = 1 .. 43.
    function automatic logic [63:0] ln_thresh(input logic [5:0] k);
        logic [63:0] t;
        unique case (k)
            6'd0:  t = 64'd3;
            6'd1:  t = 64'd8;
            6'd2:  t = 64'd21;
            6'd3:  t = 64'd55;
            6'd4:  t = 64'd149;
            6'd5:  t = 64'd404;
            6'd6:  t = 64'd1097;
            6'd7:  t = 64'd2981;
            6'd8:  t = 64'd8104;
            6'd9:  t = 64'd22027;
            6'd10: t = 64'd59875;
            6'd11: t = 64'd162755;
            6'd12: t = 64'd442414;
            6'd13: t = 64'd1202605;
            6'd14: t = 64'd3269018;
            6'd15: t = 64'd8886111;
            6'd16: t = 64'd24154953;
            6'd17: t = 64'd65659970;
            6'd18: t = 64'd178482301;
            6'd19: t = 64'd485165196;
            6'd20: t = 64'd1318815735;
            6'd21: t = 64'd3584912847;
            6'd22: t = 64'd9744803447;
            6'd23: t = 64'd26489122130;
            6'd24: t = 64'd72004899338;
            6'd25: t = 64'd195729609429;
            6'd26: t = 64'd532048240602;
            6'd27: t = 64'd1446257064292;
            6'd28: t = 64'd3931334297145;
            6'd29: t = 64'd10686474581525;
            6'd30: t = 64'd29048849665248;
            6'd31: t = 64'd78962960182681;
            6'd32: t = 64'd214643579785917;
            6'd33: t = 64'd583461742527455;
            6'd34: t = 64'd1586013452313431;
            6'd35: t = 64'd4311231547115196;
            6'd36: t = 64'd11719142372802612;
            6'd37: t = 64'd31855931757113757;
            6'd38: t = 64'd86593400423993747;
            6'd39: t = 64'd235385266837019986;
            6'd40: t = 64'd639843493530054950;
            6'd41: t = 64'd1739274941520501048;
            6'd42: t = 64'd4727839468229346562;
            default: t = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return t;
    endfunction

endpackage

[rtl/rpn_checked_integer_evaluator_unit.sv]
// Top level: operand stack, token sequencer and output register of the evaluator.
//
//  channel   direction  payload   handshake
//  in        input      rpn_in_t  in_valid / in_ready
//  out       output     rpn_out_t out_valid / out_ready
//
// Push, unused codes and errors found on acceptance skip the arithmetic unit. Concatenate
// grows its power of ten by one decimal digit of b a cycle, ln tests one threshold a cycle,
// divide and modulo produce one quotient bit a cycle, and multiply, concatenate and power
// use the shared 64 x 64 multiplier.
// Reset empties the stack and clears the error latch at once; the stack memory is not
// cleared. in_ready is low while a token is worked on; a result that waits to be taken
// holds the next token only when that token is ready to report.
module rpn_checked_integer_evaluator_unit import rpn_pkg::*;
#(
    parameter int STACK_ENTRIES = STACK_ENTRIES_DEF,
    parameter int POS_BITS      = POS_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rpn_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output rpn_out_t out_data
);

    localparam int AW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
    localparam int DW = $clog2(STACK_ENTRIES + 1);

    typedef enum logic [2:0] {
        T_IDLE, T_READ_B, T_READ_A, T_EXEC, T_WAIT, T_REPORT, T_RD_TOP, T_OUT
    } top_state_t;

    top_state_t       state_reg;
    rpn_in_t          tok_reg;
    logic [DW-1:0]    depth_reg;
    logic [3:0]       err_reg;
    logic [POS_BITS-1:0] epos_reg;
    logic [63:0]      stack_mem [STACK_ENTRIES];
    logic [63:0]      rd_reg;
    logic [63:0]      b_reg;
    rpn_alu_cmd_t     cmd_reg;
    rpn_alu_rsp_t     rsp;
    rpn_out_t         out_reg;
    logic             out_valid_reg;
    logic [POS_BITS-1:0] tok_pos;

    rpn_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_reg),
        .rsp   (rsp)
    );

    assign tok_pos = POS_BITS'(tok_reg.token_pos);

    // Token sequencer, stack memory and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            depth_reg     <= '0;
            err_reg       <= ST_OK;
            epos_reg      <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg.start <= 1'b0;
        end
        else
        begin
            cmd_reg.start <= 1'b0;
            // The result register refills from a report and empties when its item is taken.
            if (state_reg == T_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_valid)
                    begin
                        tok_reg <= in_data;
                        if (err_reg != ST_OK)
                            state_reg <= T_REPORT;
                        else if (in_data.mode == OP_PUSH)
                        begin
                            if (depth_reg >= DW'(STACK_ENTRIES))
                            begin
                                err_reg  <= ST_FULL;
                                epos_reg <= POS_BITS'(in_data.token_pos);
                            end
                            else
                            begin
                                stack_mem[depth_reg[AW-1:0]] <= {1'b0, in_data.literal};
                                depth_reg <= depth_reg + DW'(1);
                            end
                            state_reg <= T_REPORT;
                        end
                        else if (in_data.mode == OP_NEG || in_data.mode == OP_LN)
                        begin
                            if (depth_reg < DW'(1))
                            begin
                                err_reg   <= ST_UNARY;
                                epos_reg  <= POS_BITS'(in_data.token_pos);
                                state_reg <= T_REPORT;
                            end
                            else
                                state_reg <= T_READ_B;
                        end
                        else if (in_data.mode >= OP_ADD && in_data.mode <= OP_POW)
                        begin
                            if (depth_reg < DW'(2))
                            begin
                                err_reg   <= ST_BINARY;
                                epos_reg  <= POS_BITS'(in_data.token_pos);
                                state_reg <= T_REPORT;
                            end
                            else
                                state_reg <= T_READ_B;
                        end
                        else
                            state_reg <= T_REPORT;
                    end
                end
                T_READ_B:
                begin
                    rd_reg    <= stack_mem[AW'(depth_reg - DW'(1))];
                    state_reg <= T_READ_A;
                end
                T_READ_A:
                begin
                    b_reg <= rd_reg;
                    if (depth_reg >= DW'(2))
                        rd_reg <= stack_mem[AW'(depth_reg - DW'(2))];
                    state_reg <= T_EXEC;
                end
                T_EXEC:
                begin
                    cmd_reg.start <= 1'b1;
                    cmd_reg.mode  <= tok_reg.mode;
                    if (tok_reg.mode == OP_NEG || tok_reg.mode == OP_LN)
                        cmd_reg.a <= b_reg;
                    else
                        cmd_reg.a <= rd_reg;
                    cmd_reg.b <= b_reg;
                    state_reg <= T_WAIT;
                end
                T_WAIT:
                begin
                    if (rsp.done)
                    begin
                        if (rsp.status != ST_OK)
                        begin
                            err_reg  <= rsp.status;
                            epos_reg <= tok_pos;
                        end
                        else if (tok_reg.mode == OP_NEG || tok_reg.mode == OP_LN)
                            stack_mem[AW'(depth_reg - DW'(1))] <= rsp.result;
                        else
                        begin
                            stack_mem[AW'(depth_reg - DW'(2))] <= rsp.result;
                            depth_reg <= depth_reg - DW'(1);
                        end
                        state_reg <= T_REPORT;
                    end
                end
                T_REPORT:
                begin
                    if (tok_reg.last && err_reg == ST_OK && depth_reg != DW'(1))
                    begin
                        err_reg  <= ST_STRUCT;
                        epos_reg <= tok_pos;
                    end
                    state_reg <= T_RD_TOP;
                end
                T_RD_TOP:
                begin
                    if (depth_reg != '0)
                        rd_reg <= stack_mem[AW'(depth_reg - DW'(1))];
                    state_reg <= T_OUT;
                end
                T_OUT:
                begin
                    // Wait until the previous result item has been taken.
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.value     <= (err_reg == ST_OK && depth_reg != '0) ?
                                             rd_reg : 64'd0;
                        out_reg.status    <= err_reg;
                        out_reg.error_pos <= 16'(epos_reg);
                        out_reg.done_res  <= tok_reg.last;
                        if (tok_reg.last)
                        begin
                            depth_reg <= '0;
                            err_reg   <= ST_OK;
                            epos_reg  <= '0;
                        end
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == T_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[rtl/rpn_mul32.sv]
// Multi-cycle 64 x 64 unsigned multiplier built from one 32 x 32 multiplier.
module rpn_mul32 import rpn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  x,
    input  logic [63:0]  y,
    output logic         done,
    output logic [127:0] prod
);

    logic [63:0]  x_reg, y_reg;
    logic [127:0] acc_reg;
    logic [2:0]   step_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  opa, opb;
    logic [63:0]  part;
    logic [127:0] part_sh;

    // Select the pair of halves for this step.
    always_comb
    begin
        opa = step_reg[0] ? x_reg[63:32] : x_reg[31:0];
        opb = step_reg[1] ? y_reg[63:32] : y_reg[31:0];
        part = opa * opb;
        part_sh = {64'd0, part} << (({6'd0, step_reg[0]} + {6'd0, step_reg[1]}) * 7'd32);
    end

    // Accumulate one partial product a cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
                x_reg    <= x;
                y_reg    <= y;
                acc_reg  <= 128'd0;
            end
            else if (busy_reg)
            begin
                acc_reg  <= acc_reg + part_sh;
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[rtl/rpn_alu.sv]
// Sequenced arithmetic unit: checked binary operators, negate and natural log.
module rpn_alu import rpn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  rpn_alu_cmd_t cmd,
    output rpn_alu_rsp_t rsp
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_MUL_WAIT, S_DIV, S_DIV_FIN, S_CAT_P, S_POW_STEP,
        S_POW_WAIT, S_LN, S_FIN
    } alu_state_t;

    alu_state_t  state_reg;
    logic [3:0]  mode_reg;
    logic [63:0] a_reg, b_reg;
    logic [63:0] ma_reg, mb_reg;
    logic [63:0] q_reg, r_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] p_reg;
    logic [63:0] m_reg, base_reg, e_reg;
    logic        pow_sq_reg;
    logic        neg_reg;
    logic [3:0]  st_reg;
    logic [63:0] res_reg;
    logic        done_reg;

    logic         mul_start;
    logic [63:0]  mul_x, mul_y;
    logic         mul_done;
    logic [127:0] mul_prod;

    logic [64:0]  rem_sh;
    logic [64:0]  rem_sub;
    logic [63:0]  sat_val;
    logic [63:0]  lim;
    logic [64:0]  cat_sum;
    logic [63:0]  p_ten;
    logic [63:0]  add_sum;
    logic [63:0]  sub_diff;

    rpn_mul32 u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Shared datapath helpers.
    always_comb
    begin
        rem_sh   = {r_reg, q_reg[63]};
        rem_sub  = rem_sh - {1'b0, mb_reg};
        sat_val  = (mul_prod[127:64] != 64'd0 || mul_prod[63:0] > SAT_CAP)
                   ? SAT_CAP : mul_prod[63:0];
        lim      = neg_reg ? MAG_MIN : MAG_MAX;
        cat_sum  = {1'b0, mul_prod[63:0]} + {1'b0, b_reg};
        p_ten    = (p_reg << 3) + (p_reg << 1);
        add_sum  = a_reg + b_reg;
        sub_diff = a_reg - b_reg;
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            mul_start <= 1'b0;
        end
        else
        begin
            done_reg  <= 1'b0;
            mul_start <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.start)
                    begin
                        mode_reg  <= cmd.mode;
                        a_reg     <= cmd.a;
                        b_reg     <= cmd.b;
                        ma_reg    <= cmd.a[63] ? (64'd0 - cmd.a) : cmd.a;
                        mb_reg    <= cmd.b[63] ? (64'd0 - cmd.b) : cmd.b;
                        st_reg    <= ST_OK;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    unique case (mode_reg)
                        OP_ADD:
                        begin
                            res_reg <= add_sum;
                            if (a_reg[63] == b_reg[63] && a_reg[63] != add_sum[63])
                                st_reg <= ST_OVF;
                            state_reg <= S_FIN;
                        end
                        OP_SUB:
                        begin
                            res_reg <= sub_diff;
                            if (a_reg[63] != b_reg[63] && a_reg[63] != sub_diff[63])
                                st_reg <= ST_OVF;
                            state_reg <= S_FIN;
                        end
                        OP_MUL:
                        begin
                            neg_reg   <= a_reg[63] != b_reg[63];
                            mul_x     <= ma_reg;
                            mul_y     <= mb_reg;
                            mul_start <= 1'b1;
                            state_reg <= S_MUL_WAIT;
                        end
                        OP_DIV, OP_MOD:
                        begin
                            if (b_reg == 64'd0)
                            begin
                                st_reg    <= ST_DIVZ;
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                q_reg     <= ma_reg;
                                r_reg     <= 64'd0;
                                cnt_reg   <= 7'd0;
                                state_reg <= S_DIV;
                            end
                        end
                        OP_CONCAT:
                        begin
                            if (b_reg[63])
                            begin
                                res_reg   <= a_reg;
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                p_reg     <= 64'd10;
                                neg_reg   <= a_reg[63];
                                state_reg <= S_CAT_P;
                            end
                        end
                        OP_POW:
                        begin
                            neg_reg <= a_reg[63] & b_reg[0];
                            if (b_reg[63])
                            begin
                                st_reg    <= ST_NEGEXP;
                                state_reg <= S_FIN;
                            end
                            else if (ma_reg <= 64'd1)
                            begin
                                m_reg     <= (ma_reg == 64'd0) ?
                                             ((b_reg == 64'd0) ? 64'd1 : 64'd0) : 64'd1;
                                cnt_reg   <= 7'd0;
                                e_reg     <= 64'd0;
                                state_reg <= S_POW_STEP;
                            end
                            else if (b_reg >= 64'd64)
                            begin
                                st_reg    <= ST_OVF;
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                m_reg     <= 64'd1;
                                base_reg  <= ma_reg;
                                e_reg     <= b_reg;
                                cnt_reg   <= 7'd0;
                                state_reg <= S_POW_STEP;
                            end
                        end
                        OP_NEG:
                        begin
                            if (a_reg == MAG_MIN)
                                st_reg <= ST_OVF;
                            res_reg   <= 64'd0 - a_reg;
                            state_reg <= S_FIN;
                        end
                        OP_LN:
                        begin
                            if (a_reg[63] || a_reg == 64'd0)
                            begin
                                st_reg    <= ST_BADLOG;
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                cnt_reg   <= 7'd0;
                                res_reg   <= 64'd0;
                                state_reg <= S_LN;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_FIN;
                        end
                    endcase
                end
                S_MUL_WAIT:
                begin
                    if (mul_done)
                    begin
                        if (mode_reg == OP_MUL)
                        begin
                            if (mul_prod[127:64] != 64'd0 || mul_prod[63:0] > lim)
                                st_reg <= ST_OVF;
                            res_reg   <= neg_reg ? (64'd0 - mul_prod[63:0]) : mul_prod[63:0];
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            // Concatenate: |a| * p + b checked against the limit.
                            if (mul_prod[127:64] != 64'd0 || cat_sum > {1'b0, lim})
                                st_reg <= ST_OVF;
                            res_reg   <= neg_reg ? (64'd0 - cat_sum[63:0]) : cat_sum[63:0];
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_CAT_P:
                begin
                    // Grow p by one decimal digit a cycle until it exceeds b or reaches 10^18.
                    if (p_reg <= b_reg && p_reg < 64'd1000000000000000000)
                        p_reg <= p_ten;
                    else
                    begin
                        if (p_reg <= b_reg)
                            p_reg <= p_ten;
                        mul_x     <= ma_reg;
                        mul_y     <= (p_reg <= b_reg) ? 64'd0 : p_reg;
                        mul_start <= 1'b1;
                        state_reg <= S_MUL_WAIT;
                        if (p_reg <= b_reg)
                        begin
                            // p would be 10^19: any non-zero a overflows.
                            if (ma_reg != 64'd0)
                                st_reg <= ST_OVF;
                        end
                    end
                end
                S_DIV:
                begin
                    // Restoring division, one quotient bit a cycle.
                    if (!rem_sub[64])
                    begin
                        r_reg <= rem_sub[63:0];
                        q_reg <= {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= rem_sh[63:0];
                        q_reg <= {q_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd63)
                        state_reg <= S_DIV_FIN;
                end
                S_DIV_FIN:
                begin
                    if (mode_reg == OP_DIV)
                    begin
                        if (a_reg == MAG_MIN && b_reg == 64'hFFFF_FFFF_FFFF_FFFF)
                            st_reg <= ST_OVF;
                        res_reg <= (a_reg[63] != b_reg[63]) ? (64'd0 - q_reg) : q_reg;
                    end
                    else
                    begin
                        // Floored modulo: remainder takes the sign of b.
                        if (r_reg == 64'd0)
                            res_reg <= 64'd0;
                        else if (a_reg[63] == b_reg[63])
                            res_reg <= b_reg[63] ? (64'd0 - r_reg) : r_reg;
                        else
                            res_reg <= b_reg[63] ? (r_reg - mb_reg) : (mb_reg - r_reg);
                    end
                    state_reg <= S_FIN;
                end
                S_POW_STEP:
                begin
                    if (e_reg == 64'd0)
                    begin
                        if (m_reg > lim)
                            st_reg <= ST_OVF;
                        res_reg   <= neg_reg ? (64'd0 - m_reg) : m_reg;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        // Multiply step if the low bit is set, else square.
                        pow_sq_reg <= !e_reg[0];
                        mul_x      <= e_reg[0] ? m_reg : base_reg;
                        mul_y      <= base_reg;
                        mul_start  <= 1'b1;
                        state_reg  <= S_POW_WAIT;
                    end
                end
                S_POW_WAIT:
                begin
                    if (mul_done)
                    begin
                        if (pow_sq_reg)
                        begin
                            base_reg <= sat_val;
                            e_reg    <= {1'b0, e_reg[63:1]};
                        end
                        else
                        begin
                            // Clearing the low bit leaves zero once the exponent is used up.
                            m_reg <= sat_val;
                            e_reg <= {e_reg[63:1], 1'b0};
                        end
                        state_reg <= S_POW_STEP;
                    end
                end
                S_LN:
                begin
                    if (a_reg >= ln_thresh(cnt_reg[5:0]))
                        res_reg <= res_reg + 64'd1;
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'(LN_STEPS - 1))
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.status = st_reg;
    assign rsp.result = res_reg;

endmodule
